// ----- hdl/ast_pkg.sv -----
package ast_pkg;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [4:0]  token_class;
        logic [31:0] token_code;
        logic [63:0] ident_text;
        logic [3:0]  ident_length;
        logic [15:0] line_number;
        logic [2:0]  error_kind;
        logic        last_of_run;
    } out_item_t;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_IDENT   = 3'd1,
        MODE_NUMBER  = 3'd2,
        MODE_COMMENT = 3'd3,
        MODE_HALTED  = 3'd4
    } mode_t;

    localparam logic [4:0] CLS_EOI       = 5'd0;
    localparam logic [4:0] CLS_EOL       = 5'd1;
    localparam logic [4:0] CLS_NUMBER    = 5'd2;
    localparam logic [4:0] CLS_IDENT     = 5'd3;
    localparam logic [4:0] CLS_REGISTER  = 5'd4;
    localparam logic [4:0] CLS_INSTR     = 5'd5;
    localparam logic [4:0] CLS_DIRECTIVE = 5'd6;
    localparam logic [4:0] CLS_PUNCT     = 5'd11;
    localparam logic [4:0] CLS_ERROR     = 5'd19;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_ILLEGAL   = 3'd1;
    localparam logic [2:0] ERR_NUM_CHAR  = 3'd2;
    localparam logic [2:0] ERR_HEX_ZERO  = 3'd3;
    localparam logic [2:0] ERR_DEC_HEX   = 3'd4;

    // token kind handed from front to back
    typedef enum logic [1:0] {
        KIND_PLAIN  = 2'd0,
        KIND_IDENT  = 2'd1
    } kind_t;

    // one raw token as queued between front and back
    typedef struct packed {
        kind_t       kind;
        logic [4:0]  token_class;
        logic [31:0] token_code;
        logic [63:0] ident_text;
        logic [3:0]  ident_length;
        logic [15:0] line_number;
        logic [2:0]  error_kind;
        logic        last_of_run;
    } raw_tok_t;

    localparam int REG_N   = 18;
    localparam int INSTR_N = 44;
    localparam int DIR_N   = 5;

    // names packed first char in low byte, with length
    function automatic logic [67:0] reg_name(input int i);
        logic [67:0] r;
        begin
            unique case (i)
                0:  r = {4'd1, 64'h41};
                1:  r = {4'd3, 64'h434341};
                2:  r = {4'd2, 64'h4241};
                3:  r = {4'd1, 64'h43};
                4:  r = {4'd2, 64'h5943};
                5:  r = {4'd4, 64'h52545044};
                6:  r = {4'd2, 64'h4350};
                7:  r = {4'd3, 64'h4C5044};
                8:  r = {4'd3, 64'h485044};
                9:  r = {4'd2, 64'h3052};
                10: r = {4'd2, 64'h3152};
                11: r = {4'd2, 64'h3252};
                12: r = {4'd2, 64'h3352};
                13: r = {4'd2, 64'h3452};
                14: r = {4'd2, 64'h3552};
                15: r = {4'd2, 64'h3652};
                16: r = {4'd2, 64'h3752};
                default: r = {4'd3, 64'h305241};
            endcase
            return r;
        end
    endfunction

    function automatic logic [67:0] instr_name(input int i);
        logic [67:0] r;
        begin
            unique case (i)
                0:  r = {4'd3, 64'h444441};
                1:  r = {4'd4, 64'h43444441};
                2:  r = {4'd3, 64'h4C4E41};
                3:  r = {4'd3, 64'h524C43};
                4:  r = {4'd3, 64'h4C5043};
                5:  r = {4'd3, 64'h434544};
                6:  r = {4'd3, 64'h434E49};
                7:  r = {4'd2, 64'h434A};
                8:  r = {4'd3, 64'h434E4A};
                9:  r = {4'd3, 64'h424E4A};
                10: r = {4'd3, 64'h5A4E4A};
                11: r = {4'd2, 64'h5A4A};
                12: r = {4'd5, 64'h4C4C41434C};
                13: r = {4'd4, 64'h504D4A4C};
                14: r = {4'd3, 64'h564F4D};
                15: r = {4'd4, 64'h58564F4D};
                16: r = {4'd3, 64'h4C524F};
                17: r = {4'd3, 64'h544552};
                18: r = {4'd4, 64'h42544553};
                19: r = {4'd4, 64'h42425553};
                20: r = {4'd3, 64'h484358};
                21: r = {4'd3, 64'h4C5258};
                22: r = {4'd3, 64'h4C554D};
                23: r = {4'd3, 64'h564944};
                24: r = {4'd3, 64'h414144};
                25: r = {4'd2, 64'h4C52};
                26: r = {4'd3, 64'h434C52};
                27: r = {4'd2, 64'h5252};
                28: r = {4'd3, 64'h435252};
                29: r = {4'd4, 64'h50415753};
                30: r = {4'd4, 64'h43564F4D};
                31: r = {4'd4, 64'h48535550};
                32: r = {4'd3, 64'h504F50};
                33: r = {4'd3, 64'h444858};
                34: r = {4'd5, 64'h4C4C414341};
                35: r = {4'd4, 64'h49544552};
                36: r = {4'd4, 64'h504D4A41};
                37: r = {4'd4, 64'h504D4A53};
                38: r = {4'd3, 64'h504D4A};
                39: r = {4'd2, 64'h424A};
                40: r = {4'd3, 64'h43424A};
                41: r = {4'd4, 64'h454E4A43};
                42: r = {4'd4, 64'h5A4E4A44};
                default: r = {4'd3, 64'h504F4E};
            endcase
            return r;
        end
    endfunction

    function automatic logic [67:0] dir_name(input int i);
        logic [67:0] r;
        begin
            unique case (i)
                0: r = {4'd3, 64'h555145};
                1: r = {4'd2, 64'h4244};
                2: r = {4'd3, 64'h444E45};
                3: r = {4'd3, 64'h47524F};
                default: r = {4'd4, 64'h41544144};
            endcase
            return r;
        end
    endfunction

endpackage

// ----- hdl/ast_front.sv -----
module ast_front #(
    parameter int IDENT_CHARS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ast_pkg::in_item_t  in_data,
    input  logic               in_valid,
    output logic               in_stall,
    output ast_pkg::raw_tok_t  tok_a,
    output ast_pkg::raw_tok_t  tok_b,
    output logic [1:0]         tok_count,
    output logic               tok_push,
    input  logic               q_room
);
    import ast_pkg::*;

    mode_t       mode_reg, mode_next;
    logic [63:0] text_reg, text_next;
    logic [3:0]  count_reg, count_next;
    logic [31:0] dec_reg, dec_next;
    logic [31:0] hex_reg, hex_next;
    logic        sawhex_reg, sawhex_next;
    logic        fzero_reg, fzero_next;
    logic [15:0] line_reg, line_next;

    logic [7:0]  c;
    logic        eoi, alpha, digit, fire;
    logic [3:0]  dval;
    raw_tok_t    ta, tb;
    logic [1:0]  n;

    assign in_stall = !q_room;
    assign fire     = in_valid && q_room;

    // saturating add of a digit to a scaled value, shared by both radices
    function automatic logic [31:0] sat_mac(input logic [35:0] m, input logic [3:0] d);
        logic [36:0] s;
        begin
            s = {1'b0, m} + {33'd0, d};
            return (s > 37'hFFFFFFFF) ? 32'hFFFFFFFF : s[31:0];
        end
    endfunction

    function automatic raw_tok_t mk(input logic [4:0] cls, input logic [31:0] code,
                                    input logic [15:0] ln, input logic [2:0] err);
        raw_tok_t t;
        begin
            t = '0;
            t.kind = KIND_PLAIN;
            t.token_class = cls;
            t.token_code = code;
            t.line_number = ln;
            t.error_kind = err;
            return t;
        end
    endfunction

    // character classification and scanner step
    always_comb
    begin
        logic        do_idle;
        logic        halt;
        logic [35:0] dm;
        logic [35:0] hm;
        raw_tok_t    it;
        raw_tok_t    t0;
        c = in_data.char_code;
        if (c >= 8'h61 && c <= 8'h7A) c = c - 8'd32;
        eoi   = in_data.end_of_input;
        alpha = (c >= 8'h41 && c <= 8'h5A);
        digit = (c >= 8'h30 && c <= 8'h39);
        dval  = digit ? c[3:0] : (c[3:0] + 4'd9);
        dm    = {dec_reg, 3'b0} + {3'b0, dec_reg, 1'b0};
        hm    = {hex_reg, 4'b0};

        mode_next   = mode_reg;
        text_next   = text_reg;
        count_next  = count_reg;
        dec_next    = dec_reg;
        hex_next    = hex_reg;
        sawhex_next = sawhex_reg;
        fzero_next  = fzero_reg;
        line_next   = line_reg;
        do_idle     = 1'b0;
        halt        = 1'b0;
        n           = 2'd0;
        ta          = '0;
        tb          = '0;
        t0          = '0;

        it = '0;
        it.kind = KIND_IDENT;
        it.token_class = CLS_IDENT;
        it.ident_text = text_reg;
        it.ident_length = count_reg;
        it.line_number = line_reg;

        unique case (mode_reg)
            MODE_HALTED:
                halt = 1'b1;
            MODE_COMMENT:
            begin
                if (eoi)
                begin
                    t0 = mk(CLS_EOI, '0, line_reg, ERR_NONE);
                    n = 2'd1;
                    mode_next = MODE_IDLE;
                end
                else if (c == 8'h0A)
                begin
                    mode_next = MODE_IDLE;
                    do_idle = 1'b1;
                end
            end
            MODE_IDENT:
            begin
                if (!eoi && (alpha || digit || c == 8'h5F))
                begin
                    if (count_reg < 4'(IDENT_CHARS) && count_reg < 4'd8)
                    begin
                        text_next = text_reg | ({56'd0, c} << {count_reg[2:0], 3'b0});
                        count_next = count_reg + 4'd1;
                    end
                end
                else
                begin
                    t0 = it;
                    n = 2'd1;
                    mode_next = MODE_IDLE;
                    do_idle = 1'b1;
                end
            end
            MODE_NUMBER:
            begin
                if (!eoi && digit)
                begin
                    dec_next = sat_mac(dm, dval);
                    hex_next = sat_mac(hm, dval);
                end
                else if (!eoi && alpha)
                begin
                    if (c >= 8'h41 && c <= 8'h46)
                    begin
                        sawhex_next = 1'b1;
                        hex_next = sat_mac(hm, dval);
                    end
                    else if (c == 8'h48)
                    begin
                        n = 2'd1;
                        if (!fzero_reg)
                        begin
                            t0 = mk(CLS_ERROR, '0, line_reg, ERR_HEX_ZERO);
                            mode_next = MODE_HALTED;
                        end
                        else
                        begin
                            t0 = mk(CLS_NUMBER, hex_reg, line_reg, ERR_NONE);
                            mode_next = MODE_IDLE;
                        end
                    end
                    else
                    begin
                        t0 = mk(CLS_ERROR, '0, line_reg, ERR_NUM_CHAR);
                        n = 2'd1;
                        mode_next = MODE_HALTED;
                    end
                end
                else if (sawhex_reg)
                begin
                    t0 = mk(CLS_ERROR, '0, line_reg, ERR_DEC_HEX);
                    n = 2'd1;
                    mode_next = MODE_HALTED;
                end
                else
                begin
                    t0 = mk(CLS_NUMBER, dec_reg, line_reg, ERR_NONE);
                    n = 2'd1;
                    mode_next = MODE_IDLE;
                    do_idle = 1'b1;
                end
            end
            default:
            begin
                mode_next = MODE_IDLE;
                do_idle = 1'b1;
            end
        endcase

        ta = t0;
        // character handling between tokens
        if (do_idle)
        begin
            raw_tok_t ti;
            logic     emit;
            ti = '0;
            emit = 1'b0;
            if (eoi)
            begin
                ti = mk(CLS_EOI, '0, line_reg, ERR_NONE);
                emit = 1'b1;
            end
            else if (c == 8'h20 || c == 8'h09 || c == 8'h0D)
                emit = 1'b0;
            else if (c == 8'h0A)
            begin
                ti = mk(CLS_EOL, '0, line_reg, ERR_NONE);
                emit = 1'b1;
                if (line_reg != 16'hFFFF) line_next = line_reg + 16'd1;
            end
            else if (c == 8'h3B)
                mode_next = MODE_COMMENT;
            else if (c == 8'h2C || c == 8'h23 || c == 8'h3A || c == 8'h2E ||
                     c == 8'h40 || c == 8'h24 || c == 8'h2B || c == 8'h2F)
            begin
                unique case (c)
                    8'h2C: ti = mk(CLS_PUNCT,        '0, line_reg, ERR_NONE);
                    8'h23: ti = mk(CLS_PUNCT + 5'd1, '0, line_reg, ERR_NONE);
                    8'h3A: ti = mk(CLS_PUNCT + 5'd2, '0, line_reg, ERR_NONE);
                    8'h2E: ti = mk(CLS_PUNCT + 5'd3, '0, line_reg, ERR_NONE);
                    8'h40: ti = mk(CLS_PUNCT + 5'd4, '0, line_reg, ERR_NONE);
                    8'h24: ti = mk(CLS_PUNCT + 5'd5, '0, line_reg, ERR_NONE);
                    8'h2B: ti = mk(CLS_PUNCT + 5'd6, '0, line_reg, ERR_NONE);
                    default: ti = mk(CLS_PUNCT + 5'd7, '0, line_reg, ERR_NONE);
                endcase
                emit = 1'b1;
            end
            else if (c == 8'h5F || alpha)
            begin
                text_next = {56'd0, c};
                count_next = 4'd1;
                mode_next = MODE_IDENT;
            end
            else if (digit)
            begin
                dec_next = {28'd0, c[3:0]};
                hex_next = {28'd0, c[3:0]};
                sawhex_next = 1'b0;
                fzero_next = (c == 8'h30);
                mode_next = MODE_NUMBER;
            end
            else
            begin
                ti = mk(CLS_ERROR, '0, line_reg, ERR_ILLEGAL);
                emit = 1'b1;
                mode_next = MODE_HALTED;
            end
            if (emit)
            begin
                if (n == 2'd0) ta = ti;
                else tb = ti;
                n = n + 2'd1;
            end
        end

        if (n == 2'd1) ta.last_of_run = 1'b1;
        if (n == 2'd2) tb.last_of_run = 1'b1;
        if (halt) n = 2'd0;
    end

    assign tok_a     = ta;
    assign tok_b     = tb;
    assign tok_count = n;
    assign tok_push  = fire && (n != 2'd0);

    // scanner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            text_reg   <= '0;
            count_reg  <= '0;
            dec_reg    <= '0;
            hex_reg    <= '0;
            sawhex_reg <= 1'b0;
            fzero_reg  <= 1'b0;
            line_reg   <= 16'd1;
        end
        else if (fire)
        begin
            mode_reg   <= mode_next;
            text_reg   <= text_next;
            count_reg  <= count_next;
            dec_reg    <= dec_next;
            hex_reg    <= hex_next;
            sawhex_reg <= sawhex_next;
            fzero_reg  <= fzero_next;
            line_reg   <= line_next;
        end
    end

endmodule

// ----- hdl/ast_queue.sv -----
module ast_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  ast_pkg::raw_tok_t push_a,
    input  ast_pkg::raw_tok_t push_b,
    input  logic [1:0]        push_count,
    input  logic              push,
    output logic              room,
    output ast_pkg::raw_tok_t head,
    output logic              head_valid,
    input  logic              pop
);
    import ast_pkg::*;

    raw_tok_t   slot_reg [4];
    logic [1:0] rd_reg, wr_reg;
    logic [2:0] fill_reg;
    logic [2:0] fill_next;

    // two free slots always take a full pair
    assign room       = (fill_reg <= 3'd2);
    assign head       = slot_reg[rd_reg];
    assign head_valid = (fill_reg != 3'd0);

    always_comb
    begin
        fill_next = fill_reg;
        if (push) fill_next = fill_next + {1'b0, push_count};
        if (pop)  fill_next = fill_next - 3'd1;
    end

    // ring pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg   <= '0;
            wr_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (push) wr_reg <= wr_reg + push_count;
            if (pop)  rd_reg <= rd_reg + 2'd1;
            fill_reg <= fill_next;
        end
    end

    // slot writes
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_a;
            if (push_count == 2'd2) slot_reg[wr_reg + 2'd1] <= push_b;
        end
    end

endmodule

// ----- hdl/ast_back.sv -----
module ast_back (
    input  logic                clk,
    input  logic                rst_n,
    input  ast_pkg::raw_tok_t   head,
    input  logic                head_valid,
    output logic                pop,
    output ast_pkg::out_item_t  out_data,
    output logic                out_valid,
    input  logic                out_stall
);
    import ast_pkg::*;

    out_item_t res_reg;
    logic      valid_reg;
    logic      load;
    logic [4:0]  cls;
    logic [31:0] code;

    // keyword lookup over the fixed tables
    always_comb
    begin
        logic [67:0] key;
        logic        found;
        key = {head.ident_length, head.ident_text};
        cls = head.token_class;
        code = head.token_code;
        found = 1'b0;
        if (head.kind == KIND_IDENT)
        begin
            for (int i = 0; i < REG_N; i++)
                if (!found && key == reg_name(i))
                begin
                    cls = CLS_REGISTER;
                    code = 32'(i);
                    found = 1'b1;
                end
            for (int i = 0; i < INSTR_N; i++)
                if (!found && key == instr_name(i))
                begin
                    cls = CLS_INSTR;
                    code = 32'(i);
                    found = 1'b1;
                end
            for (int i = 0; i < DIR_N; i++)
                if (!found && key == dir_name(i))
                begin
                    cls = CLS_DIRECTIVE + 5'(i);
                    code = '0;
                    found = 1'b1;
                end
        end
    end

    assign load = head_valid && (!valid_reg || !out_stall);
    assign pop  = load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (!out_stall)
            valid_reg <= 1'b0;
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg.token_class  <= cls;
            res_reg.token_code   <= code;
            res_reg.ident_text   <= head.ident_text;
            res_reg.ident_length <= head.ident_length;
            res_reg.line_number  <= head.line_number;
            res_reg.error_kind   <= head.error_kind;
            res_reg.last_of_run  <= head.last_of_run;
        end
    end

    assign out_data  = res_reg;
    assign out_valid = valid_reg;

endmodule

// ----- hdl/assembly_source_tokenizer.sv -----
// channel   dir  handshake          payload
// in        in   in_valid/in_stall  in_item_t (char_code, end_of_input)
// out       out  out_valid/out_stall out_item_t (one token)
//
// one character per cycle unless stalled; a character gives zero, one or two tokens
// tokens pass a four-slot queue, then a table lookup and the output register
// a pair of tokens leaves the output one token at a time; the queue absorbs it
// input stalls while fewer than two slots are free
// reset clears scanner, queue and output valid; line count starts at one
module assembly_source_tokenizer #(
    parameter int IDENT_CHARS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ast_pkg::in_item_t   in_data,
    input  logic                in_valid,
    output logic                in_stall,
    output ast_pkg::out_item_t  out_data,
    output logic                out_valid,
    input  logic                out_stall
);
    import ast_pkg::*;

    raw_tok_t   tok_a, tok_b, head;
    logic [1:0] tok_count;
    logic       tok_push, q_room, head_valid, pop;

    ast_front #(.IDENT_CHARS(IDENT_CHARS)) u_front (
        .clk(clk), .rst_n(rst_n), .in_data(in_data), .in_valid(in_valid),
        .in_stall(in_stall), .tok_a(tok_a), .tok_b(tok_b), .tok_count(tok_count),
        .tok_push(tok_push), .q_room(q_room)
    );

    ast_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push_a(tok_a), .push_b(tok_b),
        .push_count(tok_count), .push(tok_push), .room(q_room), .head(head),
        .head_valid(head_valid), .pop(pop)
    );

    ast_back u_back (
        .clk(clk), .rst_n(rst_n), .head(head), .head_valid(head_valid), .pop(pop),
        .out_data(out_data), .out_valid(out_valid), .out_stall(out_stall)
    );

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        tok_push |-> q_room) else $error("push without room");

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid) else $error("pop from empty queue");

    a_err_class: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.error_kind != ERR_NONE |-> out_data.token_class == CLS_ERROR)
        else $error("error kind on non-error token");

endmodule
